// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define TAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tas assertion failed");

// next-cycle implication, clocked on clk, disabled in reset
`define TAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tas assertion failed");

`endif

// ===== rtl/tas_pkg.sv =====
// types, constants and grid geometry for the tactile actuator spreader
package tas_pkg;

  localparam int CHEST_COLS = 4;
  localparam int CHEST_ROWS = 4;
  localparam int ARM_COLS   = 2;
  localparam int ARM_ROWS   = 4;
  localparam int NECK_COLS  = 2;
  localparam int NECK_ROWS  = 1;

  localparam int CHEST_N = CHEST_COLS * CHEST_ROWS;
  localparam int ARM_N   = ARM_COLS * ARM_ROWS;

  localparam int OP_W    = 2;
  localparam int POS_W   = 13;
  localparam int FRAC_W  = 12;
  localparam int FACT_W  = 4;
  localparam int SCALE_W = POS_W + FACT_W;
  localparam int CELL_W  = SCALE_W - FRAC_W;
  localparam int NUM_W   = 14;
  localparam int IDX_W   = 11;
  localparam int LVL_W   = 8;
  localparam int COL_W   = 4;
  localparam int PROD_W  = NUM_W + LVL_W;
  localparam int SLOTS   = 4;
  localparam int CNT_W   = 3;
  localparam int SLOT_W  = 2;

  localparam logic [OP_W-1:0] OP_CHEST = 2'd0;
  localparam logic [OP_W-1:0] OP_ARM   = 2'd1;
  localparam logic [OP_W-1:0] OP_NECK  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic [POS_W-1:0]  ONE_Q12   = 13'd4096;
  localparam logic [NUM_W-1:0]  NUM_ONE   = 14'd4096;
  localparam logic [NUM_W-1:0]  NUM_TWO   = 14'd8192;
  localparam logic [FACT_W-1:0] CHEST_FACT = FACT_W'(CHEST_COLS - 1);
  localparam logic [FACT_W-1:0] ARM_FACT   = FACT_W'(ARM_COLS - 1);
  localparam logic [FACT_W-1:0] CHEST_FACT_Y = FACT_W'(CHEST_ROWS - 1);
  localparam logic [FACT_W-1:0] ARM_FACT_Y   = FACT_W'(ARM_ROWS - 1);
  localparam logic [COL_W-1:0]  NECK_MAX   = COL_W'(NECK_COLS - 1);
  localparam logic [IDX_W-1:0]  CHEST_COLS_I = IDX_W'(CHEST_COLS);
  localparam logic [IDX_W-1:0]  ARM_COLS_I   = IDX_W'(ARM_COLS);
  localparam logic [IDX_W-1:0]  ARM_BASE     = IDX_W'(CHEST_N);
  localparam logic [IDX_W-1:0]  NECK_BASE    = IDX_W'(CHEST_N + ARM_N);

  localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 3'd2;
  localparam logic [CNT_W-1:0] CNT_FOUR = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [COL_W-1:0] neck_column;
    logic [LVL_W-1:0] neck_level;
  } tas_item_t;

  typedef struct packed {
    logic [SLOTS-1:0][LVL_W-1:0] idx;
    logic [SLOTS-1:0][LVL_W-1:0] lvl;
    logic [CNT_W-1:0]            cnt;
  } tas_bundle_t;

endpackage

// ===== rtl/tas_spread_calc.sv =====
// three-stage pipeline: scale, split and weigh, multiply by full level
module tas_spread_calc (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tas_pkg::tas_item_t        in_item,
  input  logic [tas_pkg::LVL_W-1:0] full_level,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tas_pkg::tas_bundle_t      out_bundle
);
  import tas_pkg::*;

  // stage 1 registers
  logic                 v1;
  logic [OP_W-1:0]      op1;
  logic [SCALE_W-1:0]   cx1, cy1;
  logic [COL_W-1:0]     col1;
  logic [LVL_W-1:0]     nlvl1;

  // stage 2 registers
  logic                            v2;
  logic [SLOTS-1:0][NUM_W-1:0]     num2;
  logic [SLOTS-1:0][LVL_W-1:0]     idx2;
  logic [CNT_W-1:0]                cnt2;
  logic                            sh2;
  logic                            neck2;
  logic [LVL_W-1:0]                nlvl2;

  // stage 3 registers
  logic        v3;
  tas_bundle_t b3;

  logic r1, r2, r3;

  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  // stage 1: saturate and scale
  logic [POS_W-1:0]  xs, ys;
  logic [FACT_W-1:0] fact_x, fact_y;
  logic [COL_W-1:0]  col_s;

  always_comb begin
    xs     = (in_item.pos_x > ONE_Q12) ? ONE_Q12 : in_item.pos_x;
    ys     = (in_item.pos_y > ONE_Q12) ? ONE_Q12 : in_item.pos_y;
    fact_x = (in_item.op == OP_ARM) ? ARM_FACT : CHEST_FACT;
    fact_y = (in_item.op == OP_ARM) ? ARM_FACT_Y : CHEST_FACT_Y;
    col_s  = (in_item.neck_column > NECK_MAX) ? NECK_MAX : in_item.neck_column;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid;
    end
    if (r1 && in_valid) begin
      op1   <= in_item.op;
      cx1   <= SCALE_W'(xs) * SCALE_W'(fact_x);
      cy1   <= SCALE_W'(ys) * SCALE_W'(fact_y);
      col1  <= col_s;
      nlvl1 <= in_item.neck_level;
    end
  end

  // stage 2: cell, fraction, corner indices and weight numerators
  logic [CELL_W-1:0]           ix, iy;
  logic [FRAC_W-1:0]           fx, fy;
  logic [NUM_W-1:0]            fxn, fyn;
  logic [IDX_W-1:0]            cols, base, i00, i10, i01, i11;
  logic [SLOTS-1:0][NUM_W-1:0] num_next;
  logic [SLOTS-1:0][IDX_W-1:0] idx_next;
  logic [CNT_W-1:0]            cnt_next;
  logic                        sh_next, neck_next;

  always_comb begin
    ix   = cx1[SCALE_W-1:FRAC_W];
    iy   = cy1[SCALE_W-1:FRAC_W];
    fx   = cx1[FRAC_W-1:0];
    fy   = cy1[FRAC_W-1:0];
    fxn  = NUM_W'(fx);
    fyn  = NUM_W'(fy);
    cols = (op1 == OP_ARM) ? ARM_COLS_I : CHEST_COLS_I;
    base = (op1 == OP_ARM) ? ARM_BASE : '0;
    i00  = base + IDX_W'(iy) * cols + IDX_W'(ix);
    i10  = i00 + IDX_W'(1);
    i01  = i00 + cols;
    i11  = i01 + IDX_W'(1);
    num_next  = '0;
    idx_next  = '0;
    cnt_next  = CNT_NONE;
    sh_next   = 1'b0;
    neck_next = 1'b0;
    unique case (op1)
      OP_CHEST, OP_ARM: begin
        idx_next[0] = i00;
        if (fx == '0 && fy == '0) begin
          cnt_next    = CNT_ONE;
          num_next[0] = NUM_ONE;
        end else if (fx == '0) begin
          cnt_next    = CNT_TWO;
          num_next[0] = NUM_ONE - fyn;
          num_next[1] = fyn;
          idx_next[1] = i01;
        end else if (fy == '0) begin
          cnt_next    = CNT_TWO;
          num_next[0] = NUM_ONE - fxn;
          num_next[1] = fxn;
          idx_next[1] = i10;
        end else begin
          cnt_next    = CNT_FOUR;
          sh_next     = 1'b1;
          num_next[0] = NUM_TWO - fxn - fyn;
          num_next[1] = NUM_ONE + fxn - fyn;
          num_next[2] = fxn + fyn;
          num_next[3] = NUM_ONE - fxn + fyn;
          idx_next[1] = i10;
          idx_next[2] = i11;
          idx_next[3] = i01;
        end
      end
      OP_NECK: begin
        cnt_next    = CNT_ONE;
        neck_next   = 1'b1;
        idx_next[0] = NECK_BASE + IDX_W'(col1);
      end
      OP_NONE: begin
        cnt_next = CNT_NONE;
      end
      default: begin
        cnt_next = CNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
    if (r2 && v1) begin
      num2  <= num_next;
      for (int i = 0; i < SLOTS; i++) begin
        idx2[i] <= idx_next[i][LVL_W-1:0];
      end
      cnt2  <= cnt_next;
      sh2   <= sh_next;
      neck2 <= neck_next;
      nlvl2 <= nlvl1;
    end
  end

  // stage 3: weights times full level; items with no result drop here
  logic [SLOTS-1:0][PROD_W-1:0] prod;
  logic [SLOTS-1:0][LVL_W-1:0]  lvl_next;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      prod[i]     = PROD_W'(num2[i]) * PROD_W'(full_level);
      lvl_next[i] = sh2 ? prod[i][FRAC_W+LVL_W:FRAC_W+1] : prod[i][FRAC_W+LVL_W-1:FRAC_W];
    end
    if (neck2) begin
      lvl_next[0] = nlvl2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2 && (cnt2 != CNT_NONE);
    end
    if (r3 && v2) begin
      b3.idx <= idx2;
      b3.lvl <= lvl_next;
      b3.cnt <= cnt2;
    end
  end

  assign out_valid  = v3;
  assign out_bundle = b3;

endmodule

// ===== rtl/tactile_actuator_spread.sv =====
// top level: config register, spread pipeline and result serializer
//
// input channel s_*: one request per touch; tuser selects chest, arm or neck,
// tdata carries position and neck fields. a request of the unused selector
// gives no results. output channel m_*: one actuator index and level per
// result; tuser[0] marks the first result of a run (clear all actuators),
// tlast the final one. a run holds one, two or four results.
// cfg channel: writes full_level, the intensity at full weight; it is always
// ready and is to be written only while no run is in flight.
// path: a request passes the three pipeline stages and then the output register
// before its first result leaves.
// output: the port sends one result a cycle while m_tready is high; a new request
// loads once the output register is empty or its last result leaves, so back to back
// requests of one result each flow at one a cycle while m_tready is high.
// reset: full_level returns to 255 and the pipeline empties.
// stall: when m_tready is low the output holds and the pipeline fills up
// stage by stage, then s_tready drops; nothing is lost or repeated.
`include "assert_macros.svh"

module tactile_actuator_spread (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pos_x[12:0], pos_y[25:13], neck_column[29:26],
                                 // neck_level[37:30], zero fill
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // actuator_index[7:0], level[15:8]
  output logic [0:0]  m_tuser,   // clear_all[0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import tas_pkg::*;

  logic [LVL_W-1:0] full_level;
  tas_item_t        item;
  tas_bundle_t      cb;
  logic             cv, load_ready;

  tas_bundle_t      buf_b;
  logic             bvalid;
  logic [SLOT_W-1:0] pos;
  logic             is_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_level <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      full_level <= cfg_data;
    end
  end

  always_comb begin
    item.op          = s_tuser;
    item.pos_x       = s_tdata[12:0];
    item.pos_y       = s_tdata[25:13];
    item.neck_column = s_tdata[29:26];
    item.neck_level  = s_tdata[37:30];
  end

  tas_spread_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (item),
    .full_level (full_level),
    .out_valid  (cv),
    .out_ready  (load_ready),
    .out_bundle (cb)
  );

  // output register walks through the slots of one run
  assign is_last    = (CNT_W'(pos) + CNT_W'(1)) == buf_b.cnt;
  assign load_ready = !bvalid || (m_tready && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      pos    <= '0;
    end else if (load_ready) begin
      bvalid <= cv;
      pos    <= '0;
    end else if (m_tready) begin
      pos <= pos + SLOT_W'(1);
    end
    if (load_ready && cv) begin
      buf_b <= cb;
    end
  end

  assign m_tvalid   = bvalid;
  assign m_tdata    = {buf_b.lvl[pos], buf_b.idx[pos]};
  assign m_tuser[0] = (pos == '0);
  assign m_tlast    = is_last;

  `TAS_ASSERT_IMP(a_cnt_legal, m_tvalid, (buf_b.cnt == CNT_ONE || buf_b.cnt == CNT_TWO || buf_b.cnt == CNT_FOUR))
  `TAS_ASSERT_IMP(a_pos_in_run, m_tvalid, (CNT_W'(pos) < buf_b.cnt))
  `TAS_ASSERT_NEXT(a_run_advance, (m_tvalid && m_tready && !m_tlast), (m_tvalid && pos == $past(pos) + SLOT_W'(1)))
  `TAS_ASSERT_NEXT(a_run_ends, (m_tvalid && m_tready && m_tlast && !cv), !m_tvalid)

endmodule
